@@ rtl/led_flash_slot_table_assert.svh @@
// ----------------------------------------------------------------------------
// led_flash_slot_table_assert.svh
// Assertion macros used by the flash slot table RTL.
// ----------------------------------------------------------------------------
`ifndef LED_FLASH_SLOT_TABLE_ASSERT_SVH
`define LED_FLASH_SLOT_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while reset is applied
`define LFST_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is applied
`define LFST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/lfst_pkg.sv @@
// ----------------------------------------------------------------------------
// lfst_pkg
// Types and constants of the LED flash slot table.
// ----------------------------------------------------------------------------
package lfst_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int SLOT_CNT_W = $clog2(SLOT_COUNT + 1);

	// Operation codes
	localparam logic [1:0] OP_ENQUEUE = 2'd0;
	localparam logic [1:0] OP_DEQUEUE = 2'd1;
	localparam logic [1:0] OP_TICK    = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] now_ms;
		logic [7:0]  led_id;
		logic [31:0] flash_interval;
		logic [7:0]  flash_count;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} req_t;

	typedef struct packed {
		logic [7:0] out_led;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       use_complement;
		logic       last_result;
	} res_t;

	// One slot as stored in the slot memory; colour is red, green, blue
	typedef struct packed {
		logic [7:0]  led;
		logic [31:0] start_time;
		logic [31:0] interval;
		logic [8:0]  phases_left;
		logic [23:0] colour;
	} slot_entry_t;

	localparam int SLOT_ENTRY_W = $bits(slot_entry_t);

	// Outcome of evaluating one slot
	typedef struct packed {
		slot_entry_t entry;
		logic        release_slot;
		logic        led_match;
		logic        use_complement;
	} slot_eval_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL
	} scan_state_t;

endpackage

@@ rtl/lfst_slot_ram.sv @@
// ----------------------------------------------------------------------------
// lfst_slot_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module lfst_slot_ram #(
	parameter int DEPTH  = 8,
	parameter int WIDTH  = 8,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port: data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/lfst_slot_update.sv @@
// ----------------------------------------------------------------------------
// lfst_slot_update
// Evaluates one slot read from memory: interval check, phase countdown,
// release and LED match for dequeue.
// ----------------------------------------------------------------------------
module lfst_slot_update (
	input  lfst_pkg::slot_entry_t entry,
	input  logic [31:0]           now_ms,
	input  logic [7:0]            led_id,
	output lfst_pkg::slot_eval_t  eval
);
	import lfst_pkg::*;

	logic [31:0] elapsed;
	logic        due;
	logic [8:0]  phases_next;

	// Elapsed time wraps modulo 2^32
	assign elapsed = now_ms - entry.start_time;
	assign due     = (elapsed >= entry.interval);

	// Count down one phase when due, never below zero
	always_comb begin
		phases_next = entry.phases_left;
		if (due && (entry.phases_left != 9'd0)) begin
			phases_next = entry.phases_left - 9'd1;
		end
	end

	// Build the write-back entry and the flags
	always_comb begin
		eval.entry             = entry;
		eval.entry.phases_left = phases_next;
		if (due) begin
			eval.entry.start_time = now_ms;
		end
		eval.release_slot   = due && (phases_next == 9'd0);
		eval.led_match      = (entry.led == led_id);
		eval.use_complement = ~phases_next[0];
	end

endmodule

@@ rtl/led_flash_slot_table.sv @@
// Enqueue takes effect in the cycle of acceptance; dequeue and tick scan
// the active slots and stall new requests until the scan ends. For each
// active slot the scan reads the slot memory (ST_READ) and then evaluates
// the slot (ST_EVAL); a tick registers one result per active slot.
// Result stalls hold the scan. Reset clears the active bits and the control
// state only; slot memory contents are left as they are.
// ----------------------------------------------------------------------------
// led_flash_slot_table
// Table of LED flash slots: enqueue, dequeue by LED, and timed tick scan
// emitting one result per active slot.
// ----------------------------------------------------------------------------
`include "led_flash_slot_table_assert.svh"

module led_flash_slot_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  lfst_pkg::req_t req_data,
	output logic           res_valid,
	input  logic           res_stall,
	output lfst_pkg::res_t res_data
);
	import lfst_pkg::*;

	scan_state_t             state_q, state_d;
	logic [SLOT_COUNT-1:0]   active_q;
	logic [SLOT_CNT_W-1:0]   idx_q;
	logic [SLOT_IDX_W-1:0]   cur_idx_q;
	logic [1:0]              op_q;
	logic [31:0]             now_q;
	logic [7:0]              led_q;
	logic                    res_valid_q;
	res_t                    res_q;

	logic                    accept;
	logic                    is_tick;
	logic                    res_free;
	logic                    step;
	logic                    found;
	logic [SLOT_IDX_W-1:0]   next_idx;
	logic                    free_found;
	logic [SLOT_IDX_W-1:0]   free_idx;
	logic                    more_after;

	logic                    ram_we;
	logic [SLOT_IDX_W-1:0]   ram_waddr;
	slot_entry_t             ram_wentry;
	logic                    ram_re;
	logic [SLOT_IDX_W-1:0]   ram_raddr;
	logic [SLOT_ENTRY_W-1:0] ram_rdata;
	slot_entry_t             rd_entry;
	slot_entry_t             enq_entry;
	slot_eval_t              eval;

	assign is_tick  = (op_q == OP_TICK);
	assign res_free = !res_valid_q || !res_stall;
	assign rd_entry = slot_entry_t'(ram_rdata);

	// Find the lowest active slot at or after the scan position
	always_comb begin
		found    = 1'b0;
		next_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (active_q[i] && (SLOT_CNT_W'(i) >= idx_q)) begin
				found    = 1'b1;
				next_idx = SLOT_IDX_W'(i);
			end
		end
	end

	// Find the lowest inactive slot for enqueue
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_IDX_W'(i);
			end
		end
	end

	// Detect any active slot beyond the one under evaluation
	always_comb begin
		more_after = 1'b0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (active_q[i] && (SLOT_IDX_W'(i) > cur_idx_q)) begin
				more_after = 1'b1;
			end
		end
	end

	// Build a new slot from the request
	always_comb begin
		enq_entry.led         = req_data.led_id;
		enq_entry.start_time  = req_data.now_ms;
		enq_entry.interval    = req_data.flash_interval;
		enq_entry.phases_left = {req_data.flash_count, 1'b0};
		enq_entry.colour      = {req_data.red, req_data.green, req_data.blue};
	end

	lfst_slot_update u_update (
		.entry  (rd_entry),
		.now_ms (now_q),
		.led_id (led_q),
		.eval   (eval)
	);

	// Slot memory; write-back only goes to the slot just read, and the next
	// read is always a higher slot, so no access overlaps another
	lfst_slot_ram #(
		.DEPTH  (SLOT_COUNT),
		.WIDTH  (SLOT_ENTRY_W),
		.ADDR_W (SLOT_IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (SLOT_ENTRY_W'(ram_wentry)),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid && ((req_data.operation == OP_DEQUEUE) ||
						(req_data.operation == OP_TICK))) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = found ? ST_EVAL : ST_IDLE;
			end
			ST_EVAL: begin
				if (!is_tick || res_free) begin
					state_d = ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control outputs
	always_comb begin
		req_stall  = (state_q != ST_IDLE);
		accept     = req_valid && (state_q == ST_IDLE);
		ram_re     = (state_q == ST_READ) && found;
		ram_raddr  = next_idx;
		step       = (state_q == ST_EVAL) && (!is_tick || res_free);
		ram_we     = 1'b0;
		ram_waddr  = free_idx;
		ram_wentry = enq_entry;
		if (accept && (req_data.operation == OP_ENQUEUE) && free_found) begin
			ram_we = 1'b1;
		end else if (step && is_tick) begin
			ram_we     = 1'b1;
			ram_waddr  = cur_idx_q;
			ram_wentry = eval.entry;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= '0;
			idx_q       <= '0;
			cur_idx_q   <= '0;
			op_q        <= OP_ENQUEUE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q  <= req_data.operation;
				idx_q <= '0;
			end
			if (accept && (req_data.operation == OP_ENQUEUE) && free_found) begin
				active_q[free_idx] <= 1'b1;
			end
			if (ram_re) begin
				cur_idx_q <= next_idx;
			end
			// Advance past the evaluated slot and drop it when a tick releases it or a dequeue matches its LED
			if (step) begin
				idx_q <= SLOT_CNT_W'(cur_idx_q) + SLOT_CNT_W'(1);
				if (is_tick ? eval.release_slot : eval.led_match) begin
					active_q[cur_idx_q] <= 1'b0;
				end
			end
			if (step && is_tick) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Request payload and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= req_data.now_ms;
			led_q <= req_data.led_id;
		end
		if (step && is_tick) begin
			res_q.out_led        <= rd_entry.led;
			res_q.out_red        <= rd_entry.colour[23:16];
			res_q.out_green      <= rd_entry.colour[15:8];
			res_q.out_blue       <= rd_entry.colour[7:0];
			res_q.use_complement <= eval.use_complement;
			res_q.last_result    <= !more_after;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	`LFST_ASSERT_NOW(a_eval_slot_active, state_q == ST_EVAL, active_q[cur_idx_q], "evaluated slot is not active")
	`LFST_ASSERT_NOW(a_enq_free_slot, ram_we && (state_q == ST_IDLE), !active_q[ram_waddr], "enqueue overwrites an active slot")
	`LFST_ASSERT_NEXT(a_scan_start, accept && (req_data.operation == OP_TICK), state_q == ST_READ, "tick did not start a scan")
	`LFST_ASSERT_NEXT(a_last_ends_scan, step && is_tick && !more_after, !found, "slot found after last result")

endmodule
